// ===== rtl/core/lbfs_pkg.sv =====
// lbfs_pkg: beat types and constants for the 13-point field stencil
// no dependencies
package lbfs_pkg;

	localparam int unsigned MagW   = 16;
	localparam int unsigned CellW  = 3 * MagW;
	localparam int unsigned CoefW  = 32;
	localparam int unsigned FieldW = 40;
	localparam int unsigned IdxW   = 6;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_FIELD_X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_FIELD_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FIELD_Z = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CENTER  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_NEAR    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DIAG    = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_FAR     = 3'd6;

	localparam logic [CoefW-1:0] RST_FIELD_X = 32'sd0;
	localparam logic [CoefW-1:0] RST_FIELD_Y = 32'sd0;
	localparam logic [CoefW-1:0] RST_FIELD_Z = 32'sd65536;
	localparam logic [CoefW-1:0] RST_CENTER  = -32'sd1572864;
	localparam logic [CoefW-1:0] RST_NEAR    = 32'sd589824;
	localparam logic [CoefW-1:0] RST_DIAG    = -32'sd131072;
	localparam logic [CoefW-1:0] RST_FAR     = -32'sd65536;

	typedef struct packed {
		logic signed [MagW-1:0] mag_x;
		logic signed [MagW-1:0] mag_y;
		logic signed [MagW-1:0] mag_z;
		logic                   start_of_grid;
	} in_beat_t;

	typedef struct packed {
		logic signed [FieldW-1:0] field_x;
		logic signed [FieldW-1:0] field_y;
		logic signed [FieldW-1:0] field_z;
		logic [IdxW-1:0]          cell_col;
		logic [IdxW-1:0]          cell_row;
		logic                     last_cell;
	} out_beat_t;

	typedef struct packed {
		logic            valid;
		logic            emit;
		logic [IdxW-1:0] col;
		logic [IdxW-1:0] row;
		logic            last;
	} ctrl_t;

endpackage

// ===== rtl/core/lbfs_ram.sv =====
// lbfs_ram: generic single-port-write, registered-read memory
// no dependencies
module lbfs_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end
endmodule

// ===== rtl/core/lbfs_comp.sv =====
// lbfs_comp: tap sums, weight products and rounding for one component
// depends on lbfs_pkg
module lbfs_comp (
	input  logic                                          clk,
	input  logic                                          en,
	input  logic [lbfs_pkg::MagW-1:0]                     center,
	input  logic [3:0][lbfs_pkg::MagW-1:0]                near,
	input  logic [3:0][lbfs_pkg::MagW-1:0]                diag,
	input  logic [3:0][lbfs_pkg::MagW-1:0]                far,
	input  logic [lbfs_pkg::CoefW-1:0]                    coef_center,
	input  logic [lbfs_pkg::CoefW-1:0]                    coef_near,
	input  logic [lbfs_pkg::CoefW-1:0]                    coef_diag,
	input  logic [lbfs_pkg::CoefW-1:0]                    coef_far,
	input  logic [lbfs_pkg::CoefW-1:0]                    applied,
	output logic signed [lbfs_pkg::FieldW-1:0]            field
);
	localparam int unsigned SW = lbfs_pkg::MagW + 2;
	localparam int unsigned PW = lbfs_pkg::CoefW + SW;
	localparam int unsigned TW = PW + 2;
	localparam int unsigned FW = lbfs_pkg::FieldW;

	logic signed [SW-1:0] center_s3, near_s3, diag_s3, far_s3;
	logic signed [PW-1:0] p_center_s4, p_near_s4, p_diag_s4, p_far_s4;
	logic signed [TW-1:0] sum_s5;
	logic signed [TW-1:0] shifted;
	logic signed [FW:0]   total;

	function automatic logic signed [SW-1:0] sum4(input logic [3:0][lbfs_pkg::MagW-1:0] v);
		logic signed [SW-1:0] acc;
		acc = '0;
		for (int i = 0; i < 4; i++) begin
			acc = acc + SW'($signed(v[i]));
		end
		return acc;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			center_s3   <= SW'($signed(center));
			near_s3     <= sum4(near);
			diag_s3     <= sum4(diag);
			far_s3      <= sum4(far);
			p_center_s4 <= PW'($signed(coef_center)) * PW'(center_s3);
			p_near_s4   <= PW'($signed(coef_near)) * PW'(near_s3);
			p_diag_s4   <= PW'($signed(coef_diag)) * PW'(diag_s3);
			p_far_s4    <= PW'($signed(coef_far)) * PW'(far_s3);
			sum_s5      <= TW'(p_center_s4) + TW'(p_near_s4) + TW'(p_diag_s4)
				+ TW'(p_far_s4);
		end
	end

	// floor shift back to q.16, add applied field, clamp to 40 bits
	always_comb begin
		shifted = sum_s5 >>> 14;
		total   = $signed(shifted[FW:0]) + (FW+1)'($signed(applied));
		if (total[FW] != total[FW-1]) begin
			field = total[FW] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
		end else begin
			field = total[FW-1:0];
		end
	end
endmodule

// ===== rtl/core/laplacian_biharmonic_field_stencil.sv =====
// laplacian_biharmonic_field_stencil: streaming 13-point laplacian minus biharmonic
// depends on lbfs_pkg, lbfs_ram, lbfs_comp
//
// Cells enter on the in channel (valid/ready) in raster order, column fastest,
// GRID_SIZE cells to a row; start_of_grid restarts the counts at cell (0,0).
// Four line stores (one RAM per row slot, read at the current column, the
// oldest slot written back with the new cell) and a 5x5 window form the
// neighborhood. A beat leaves on the out channel for every interior cell, two
// cells from each edge, once the cell two rows below and two columns right of
// it has entered.
// Throughput: one cell per cycle while the receiver does not stall; an input
// beat passes RAM read, window, tap sums, products, sum and output register.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must use it only while the block is idle; the block does not enforce this.
// Reset clears counts, window, coefficients to their defaults and all valid
// flags; line store content is undefined, but no beat is emitted from it before it is written.
// When the receiver stalls, the whole pipeline holds and in_ready drops.
module laplacian_biharmonic_field_stencil #(
	parameter int unsigned GRID_SIZE = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  lbfs_pkg::in_beat_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output lbfs_pkg::out_beat_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [lbfs_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [lbfs_pkg::CoefW-1:0]           cfg_data
);
	localparam int unsigned CW = $clog2(GRID_SIZE);
	localparam int unsigned XW = (CW > lbfs_pkg::IdxW) ? CW : lbfs_pkg::IdxW;
	localparam int unsigned MW = lbfs_pkg::MagW;
	localparam int unsigned DW = lbfs_pkg::CellW;

	logic [lbfs_pkg::CoefW-1:0] field_x_q, field_y_q, field_z_q;
	logic [lbfs_pkg::CoefW-1:0] center_q, near_q, diag_q, far_q;

	logic [CW-1:0] col_q, row_q, col_cur, row_cur;
	logic          adv, in_acc;
	logic [DW-1:0] cell_in;
	logic [DW-1:0] rd [4];
	logic [DW-1:0] newcol [5];
	logic [DW-1:0] window_q [5][5];
	logic [DW-1:0] cell_s1;
	logic [1:0]    slot_s1;
	lbfs_pkg::ctrl_t ctrl_in, ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	logic [XW-1:0] col_x, row_x;
	logic signed [lbfs_pkg::FieldW-1:0] fld [3];

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign in_acc   = in_valid && in_ready;
	assign cell_in  = {in_data.mag_z, in_data.mag_y, in_data.mag_x};
	assign col_cur  = in_data.start_of_grid ? '0 : col_q;
	assign row_cur  = in_data.start_of_grid ? '0 : row_q;
	assign col_x    = XW'(col_cur) - XW'(2);
	assign row_x    = XW'(row_cur) - XW'(2);

	always_comb begin
		ctrl_in.valid = in_acc;
		ctrl_in.emit  = (row_cur >= CW'(4)) && (col_cur >= CW'(4));
		ctrl_in.col   = col_x[lbfs_pkg::IdxW-1:0];
		ctrl_in.row   = row_x[lbfs_pkg::IdxW-1:0];
		ctrl_in.last  = (row_cur == CW'(GRID_SIZE - 1)) && (col_cur == CW'(GRID_SIZE - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_x_q <= lbfs_pkg::RST_FIELD_X;
			field_y_q <= lbfs_pkg::RST_FIELD_Y;
			field_z_q <= lbfs_pkg::RST_FIELD_Z;
			center_q  <= lbfs_pkg::RST_CENTER;
			near_q    <= lbfs_pkg::RST_NEAR;
			diag_q    <= lbfs_pkg::RST_DIAG;
			far_q     <= lbfs_pkg::RST_FAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbfs_pkg::REG_FIELD_X: field_x_q <= cfg_data;
				lbfs_pkg::REG_FIELD_Y: field_y_q <= cfg_data;
				lbfs_pkg::REG_FIELD_Z: field_z_q <= cfg_data;
				lbfs_pkg::REG_CENTER:  center_q  <= cfg_data;
				lbfs_pkg::REG_NEAR:    near_q    <= cfg_data;
				lbfs_pkg::REG_DIAG:    diag_q    <= cfg_data;
				lbfs_pkg::REG_FAR:     far_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_cur == CW'(GRID_SIZE - 1)) begin
				col_q <= '0;
				row_q <= (row_cur == CW'(GRID_SIZE - 1)) ? '0 : row_cur + CW'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_line
		lbfs_ram #(.WIDTH(DW), .DEPTH(GRID_SIZE)) u_line (
			.clk   (clk),
			.we    (in_acc && (row_cur[1:0] == 2'(g))),
			.waddr (col_cur),
			.wdata (cell_in),
			.re    (in_acc),
			.raddr (col_cur),
			.rdata (rd[g])
		);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cell_s1 <= cell_in;
			slot_s1 <= row_cur[1:0];
		end
	end

	always_comb begin
		for (int s = 0; s < 4; s++) begin
			newcol[s] = rd[2'(slot_s1 + 2'(s))];
		end
		newcol[4] = cell_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 5; s++) begin
				for (int j = 0; j < 5; j++) begin
					window_q[s][j] <= '0;
				end
			end
		end else if (adv && ctrl_s1.valid) begin
			for (int s = 0; s < 5; s++) begin
				for (int j = 0; j < 4; j++) begin
					window_q[s][j] <= window_q[s][j+1];
				end
				window_q[s][4] <= newcol[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_comp
		logic [3:0][MW-1:0] near_t, diag_t, far_t;
		assign near_t = {window_q[1][2][k*MW +: MW], window_q[3][2][k*MW +: MW],
			window_q[2][1][k*MW +: MW], window_q[2][3][k*MW +: MW]};
		assign diag_t = {window_q[1][1][k*MW +: MW], window_q[1][3][k*MW +: MW],
			window_q[3][1][k*MW +: MW], window_q[3][3][k*MW +: MW]};
		assign far_t  = {window_q[0][2][k*MW +: MW], window_q[4][2][k*MW +: MW],
			window_q[2][0][k*MW +: MW], window_q[2][4][k*MW +: MW]};
		lbfs_comp u_comp (
			.clk         (clk),
			.en          (adv),
			.center      (window_q[2][2][k*MW +: MW]),
			.near        (near_t),
			.diag        (diag_t),
			.far         (far_t),
			.coef_center (center_q),
			.coef_near   (near_q),
			.coef_diag   (diag_q),
			.coef_far    (far_q),
			.applied     ((k == 0) ? field_x_q : ((k == 1) ? field_y_q : field_z_q)),
			.field       (fld[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctrl_s5.valid && ctrl_s5.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl_s5.valid && ctrl_s5.emit) begin
			out_data.field_x   <= fld[0];
			out_data.field_y   <= fld[1];
			out_data.field_z   <= fld[2];
			out_data.cell_col  <= ctrl_s5.col;
			out_data.cell_row  <= ctrl_s5.row;
			out_data.last_cell <= ctrl_s5.last;
		end
	end

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.start_of_grid |=> col_q == CW'(1) && row_q == '0)
		else $error("start mark did not restart the raster counts");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_cell |->
			out_data.cell_col == lbfs_pkg::IdxW'(GRID_SIZE - 3)
			&& out_data.cell_row == lbfs_pkg::IdxW'(GRID_SIZE - 3))
		else $error("last cell flag on a non-final interior cell");

	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> !ctrl_s1.valid || $stable(ctrl_s1))
		else $error("pipeline advanced while output stalled");
endmodule
